@@ src/ctv_pkg.sv @@
`default_nettype none

package ctv_pkg;

   localparam int CTV_COUNT_W = 17;
   localparam int CTV_MAX_W   = 16;
   localparam int CTV_CP_W    = 21;
   localparam int CTV_TIME_W  = 64;
   localparam int CTV_ADDR_W  = 3;
   localparam int CTV_DATA_W  = 32;

   localparam logic [CTV_COUNT_W-1:0] CTV_COUNT_MAX       = 17'h1FFFF;
   localparam logic [CTV_MAX_W-1:0]   CTV_MAX_BYTES_RESET = 16'd4096;

   localparam logic [CTV_CP_W-1:0] CTV_MIN_2B    = 21'h80;
   localparam logic [CTV_CP_W-1:0] CTV_MIN_3B    = 21'h800;
   localparam logic [CTV_CP_W-1:0] CTV_MIN_4B    = 21'h10000;
   localparam logic [CTV_CP_W-1:0] CTV_SURR_LO   = 21'hD800;
   localparam logic [CTV_CP_W-1:0] CTV_SURR_HI   = 21'hDFFF;
   localparam logic [CTV_CP_W-1:0] CTV_CP_MAX    = 21'h10FFFF;

   localparam logic [7:0] CTV_CHR_SPACE = 8'h20;
   localparam logic [7:0] CTV_CHR_TAB   = 8'h09;
   localparam logic [7:0] CTV_CHR_LF    = 8'h0A;
   localparam logic [7:0] CTV_CHR_CR    = 8'h0D;

   // verdict codes, ranked by priority
   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_TIME    = 3'd1,
      KIND_LONG    = 3'd2,
      KIND_EMPTY   = 3'd3,
      KIND_UTF8    = 3'd4,
      KIND_CONTROL = 3'd5
   } ctv_kind_type;

   // smallest legal code point of the open sequence
   typedef enum logic [1:0] {
      CLASS_NONE = 2'd0,
      CLASS_2B   = 2'd1,
      CLASS_3B   = 2'd2,
      CLASS_4B   = 2'd3
   } ctv_class_type;

   typedef enum logic {
      CSR_MAX_TEXT_BYTES = 1'b0
   } ctv_csr_type;

   // per-segment status, including the beat being accepted
   typedef struct packed {
      logic [CTV_COUNT_W-1:0] byte_count;
      logic                   seen_non_ws;
      logic                   control_seen;
   } ctv_seg_status_type;

endpackage

`default_nettype wire

@@ src/caption_text_validator.sv @@
// The verdict beat appears on rsp in the cycle after the last text beat is accepted.
// Throughput: one text beat per cycle; the decode and counters update in the accepting cycle
// and the single result register is the only stage, so req stalls only while that
// register holds a verdict that rsp_tready has not taken.
// Reset (synchronous, active high): clears all segment state, drops any pending verdict
// and loads max_text_bytes with 4096.
`default_nettype none

module caption_text_validator
   import ctv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: text_byte[7:0], start_time_us[71:8], end_time_us[135:72]
   input  wire logic [135:0]          req_tdata,
   // req_tuser: byte_valid
   input  wire logic                  req_tuser,
   input  wire logic                  req_tlast,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // rsp_tdata: error_kind[2:0], zero fill [7:3]
   output logic [7:0]                 rsp_tdata,
   // rsp_tuser: segment_ok
   output logic                       rsp_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CTV_ADDR_W-1:0] csr_paddr,
   input  wire logic [CTV_DATA_W-1:0] csr_pwdata,
   output logic [CTV_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic                   accept;
   logic [7:0]             text_byte;
   logic signed [CTV_TIME_W-1:0] start_time;
   logic signed [CTV_TIME_W-1:0] end_time;
   logic                   utf8_bad;
   ctv_seg_status_type     seg_status;
   ctv_kind_type           kind;
   ctv_csr_type            csr_index;
   logic                   csr_write;

   logic [CTV_MAX_W-1:0]   max_bytes_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   ctv_kind_type           rsp_kind_ff;

   // unpack the request beat
   assign text_byte  = req_tdata[7:0];
   assign start_time = req_tdata[71:8];
   assign end_time   = req_tdata[135:72];

   // take a beat whenever the result register is free or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   ctv_utf8_dec u_dec (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .byte_valid (req_tuser),
      .last_byte  (req_tlast),
      .text_byte  (text_byte),
      .utf8_bad   (utf8_bad)
   );

   ctv_seg_track u_track (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .byte_valid (req_tuser),
      .last_byte  (req_tlast),
      .text_byte  (text_byte),
      .seg_status (seg_status)
   );

   // rank the checks; the first failing one wins
   always_comb begin
      if (end_time <= start_time) begin
         kind = KIND_TIME;
      end else if (seg_status.byte_count > {1'b0, max_bytes_ff}) begin
         kind = KIND_LONG;
      end else if (!seg_status.seen_non_ws) begin
         kind = KIND_EMPTY;
      end else if (utf8_bad) begin
         kind = KIND_UTF8;
      end else if (seg_status.control_seen) begin
         kind = KIND_CONTROL;
      end else begin
         kind = KIND_NONE;
      end
   end

   // result register: load on the last beat, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept && req_tlast) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         rsp_kind_ff <= kind;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_kind_ff};
   assign rsp_tuser  = (rsp_kind_ff == KIND_NONE);

   // register file: one word, write in the access phase
   assign csr_index  = ctv_csr_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= CTV_MAX_BYTES_RESET;
      end else if (csr_write && (csr_index == CSR_MAX_TEXT_BYTES)) begin
         max_bytes_ff <= csr_pwdata[CTV_MAX_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_MAX_TEXT_BYTES: csr_prdata = {{(CTV_DATA_W-CTV_MAX_W){1'b0}}, max_bytes_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // a verdict only follows an accepted last beat
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(accept && req_tlast))
      else $error("verdict raised without a last beat");

   // the ok flag and the code agree
   a_ok_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == (rsp_tdata[2:0] == KIND_NONE)))
      else $error("segment_ok disagrees with error_kind");

   // a bad time window outranks every other check
   a_time_first: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast && (end_time <= start_time)) |=> (rsp_tdata[2:0] == KIND_TIME))
      else $error("time check not reported first");

   // a held verdict does not change while stalled
   a_hold_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_kind_ff))
      else $error("stalled verdict changed");

endmodule

`default_nettype wire

@@ src/ctv_utf8_dec.sv @@
`default_nettype none

module ctv_utf8_dec
   import ctv_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic       byte_valid,
   input  wire logic       last_byte,
   input  wire logic [7:0] text_byte,
   output logic            utf8_bad
);

   logic [1:0]          pend_ff, pend_in;
   logic [CTV_CP_W-1:0] part_ff, part_in;
   ctv_class_type       cls_ff, cls_in;
   logic                err_ff, err_in;

   logic [CTV_CP_W-1:0] cp;
   logic [CTV_CP_W-1:0] cp_lo;
   logic                cp_bad;

   assign cp = {part_ff[CTV_CP_W-7:0], text_byte[5:0]};

   always_comb begin
      case (cls_ff)
         CLASS_2B: cp_lo = CTV_MIN_2B;
         CLASS_3B: cp_lo = CTV_MIN_3B;
         default:  cp_lo = CTV_MIN_4B;
      endcase
   end

   assign cp_bad = (cp < cp_lo) || ((cp >= CTV_SURR_LO) && (cp <= CTV_SURR_HI))
                   || (cp > CTV_CP_MAX);

   always_comb begin
      pend_in = pend_ff;
      part_in = part_ff;
      cls_in  = cls_ff;
      err_in  = err_ff;
      if (byte_valid) begin
         if (pend_ff == 2'd0) begin
            if (text_byte[7]) begin
               if (text_byte[7:5] == 3'b110) begin
                  pend_in = 2'd1;
                  part_in = {16'd0, text_byte[4:0]};
                  cls_in  = CLASS_2B;
               end else if (text_byte[7:4] == 4'b1110) begin
                  pend_in = 2'd2;
                  part_in = {17'd0, text_byte[3:0]};
                  cls_in  = CLASS_3B;
               end else if (text_byte[7:3] == 5'b11110) begin
                  pend_in = 2'd3;
                  part_in = {18'd0, text_byte[2:0]};
                  cls_in  = CLASS_4B;
               end else begin
                  err_in  = 1'b1;
                  part_in = '0;
                  cls_in  = CLASS_NONE;
               end
            end
         end else if (text_byte[7:6] != 2'b10) begin
            // drop the open sequence
            err_in  = 1'b1;
            pend_in = 2'd0;
            part_in = '0;
            cls_in  = CLASS_NONE;
         end else begin
            pend_in = pend_ff - 2'd1;
            part_in = cp;
            if (pend_ff == 2'd1) begin
               if (cp_bad) begin
                  err_in = 1'b1;
               end
               part_in = '0;
               cls_in  = CLASS_NONE;
            end
         end
      end
   end

   assign utf8_bad = err_in || (pend_in != 2'd0);

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         pend_ff <= 2'd0;
         part_ff <= '0;
         cls_ff  <= CLASS_NONE;
         err_ff  <= 1'b0;
      end else if (step) begin
         pend_ff <= pend_in;
         part_ff <= part_in;
         cls_ff  <= cls_in;
         err_ff  <= err_in;
      end
   end

endmodule

`default_nettype wire

@@ src/ctv_seg_track.sv @@
`default_nettype none

module ctv_seg_track
   import ctv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic        byte_valid,
   input  wire logic        last_byte,
   input  wire logic [7:0]  text_byte,
   output ctv_seg_status_type seg_status
);

   logic [CTV_COUNT_W-1:0] count_ff, count_in;
   logic                   non_ws_ff, non_ws_in;
   logic                   ctrl_ff, ctrl_in;
   logic                   is_ws;

   assign is_ws = (text_byte == CTV_CHR_SPACE) || (text_byte == CTV_CHR_TAB)
                  || (text_byte == CTV_CHR_LF) || (text_byte == CTV_CHR_CR);

   always_comb begin
      count_in  = count_ff;
      non_ws_in = non_ws_ff;
      ctrl_in   = ctrl_ff;
      if (byte_valid) begin
         if (count_ff != CTV_COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
         if (!is_ws) begin
            non_ws_in = 1'b1;
         end
         if ((text_byte < CTV_CHR_SPACE) && (text_byte != CTV_CHR_LF)) begin
            ctrl_in = 1'b1;
         end
      end
   end

   // byte_count, seen_non_ws, control_seen from the top bit down
   assign seg_status = {count_in, non_ws_in, ctrl_in};

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         count_ff  <= '0;
         non_ws_ff <= 1'b0;
         ctrl_ff   <= 1'b0;
      end else if (step) begin
         count_ff  <= count_in;
         non_ws_ff <= non_ws_in;
         ctrl_ff   <= ctrl_in;
      end
   end

endmodule

`default_nettype wire

@@ sim/tb_caption_text_validator.sv @@
`timescale 1ns / 100ps

module tb_caption_text_validator;
   import ctv_pkg::*;

   // One text beat as it travels on req. Times only matter on the last beat.
   typedef struct {
      logic [7:0] text;
      bit         valid;
      bit         last;
      longint     start_us;
      longint     finish_us;
   } text_beat_type;

   // Directed row: the beat plus, where it is obvious, the verdict typed in by hand.
   typedef struct {
      text_beat_type beat;
      bit            typed;
      ctv_kind_type  kind;
   } probe_row_type;

   localparam longint T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam longint T_MIN = 64'h8000_0000_0000_0000;
   localparam logic [CTV_ADDR_W-1:0] LIMIT_ADDR = CTV_ADDR_W'(4 * int'(CSR_MAX_TEXT_BYTES));
   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 75;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   // req_tdata: text_byte[7:0], start_time_us[71:8], end_time_us[135:72]
   logic [135:0]          req_tdata = '0;
   // req_tuser: byte_valid
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // rsp_tdata: error_kind[2:0], zero fill [7:3]
   logic [7:0]            rsp_tdata;
   // rsp_tuser: segment_ok
   logic                  rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CTV_ADDR_W-1:0] csr_paddr = '0;
   logic [CTV_DATA_W-1:0] csr_pwdata = '0;
   logic [CTV_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   caption_text_validator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Shadow of the block: the length limit and the per-segment decode state.
   // ---------------------------------------------------------------------------------------
   logic [15:0]            text_limit = CTV_MAX_BYTES_RESET;
   logic [CTV_COUNT_W-1:0] seg_bytes = '0;
   logic [1:0]             cont_left = '0;
   logic [CTV_CP_W-1:0]    cp_accum = '0;
   ctv_class_type          cp_class = CLASS_NONE;
   bit                     any_visible = 1'b0;
   bit                     utf8_broken = 1'b0;
   bit                     ctrl_seen = 1'b0;

   ctv_kind_type  pending_verdicts[$];   // verdicts owed by the block, oldest first
   text_beat_type seg_beats[$];          // random segment being assembled
   bit            req_calm = 1'b0;       // no sender gaps while set
   int            text_items = 0;
   int            mismatch_count = 0;
   int            kind_tally[6] = '{default: 0};

   task automatic flag_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatch_count++;
   endtask

   // Sticky decode error: drop whatever sequence is open.
   function automatic void break_utf8();
      utf8_broken = 1'b1;
      cont_left = '0;
      cp_accum = '0;
      cp_class = CLASS_NONE;
   endfunction

   // Fold one accepted beat into the shadow state; return 1 with the verdict on a last beat.
   function automatic bit absorb_text_beat(input text_beat_type b, output ctv_kind_type verdict);
      logic [CTV_CP_W-1:0] floor_cp;
      verdict = KIND_NONE;
      if (b.valid) begin
         if (seg_bytes != CTV_COUNT_MAX)
            seg_bytes++;
         if (!(b.text inside {CTV_CHR_SPACE, CTV_CHR_TAB, CTV_CHR_LF, CTV_CHR_CR}))
            any_visible = 1'b1;
         if (b.text < CTV_CHR_SPACE && b.text != CTV_CHR_LF)
            ctrl_seen = 1'b1;
         if (cont_left == 0) begin
            if (!b.text[7]) begin
               // plain ASCII, nothing to track
            end else if (b.text[7:5] == 3'b110) begin
               cont_left = 2'd1;
               cp_accum = CTV_CP_W'(b.text[4:0]);
               cp_class = CLASS_2B;
            end else if (b.text[7:4] == 4'b1110) begin
               cont_left = 2'd2;
               cp_accum = CTV_CP_W'(b.text[3:0]);
               cp_class = CLASS_3B;
            end else if (b.text[7:3] == 5'b11110) begin
               cont_left = 2'd3;
               cp_accum = CTV_CP_W'(b.text[2:0]);
               cp_class = CLASS_4B;
            end else begin
               break_utf8();
            end
         end else if (b.text[7:6] != 2'b10) begin
            break_utf8();
         end else begin
            cp_accum = {cp_accum[14:0], b.text[5:0]};
            cont_left--;
            if (cont_left == 0) begin
               case (cp_class)
                  CLASS_2B: floor_cp = CTV_MIN_2B;
                  CLASS_3B: floor_cp = CTV_MIN_3B;
                  default:  floor_cp = CTV_MIN_4B;
               endcase
               // overlong, surrogate half or beyond the Unicode range
               if (cp_accum < floor_cp || cp_accum > CTV_CP_MAX ||
                   (cp_accum >= CTV_SURR_LO && cp_accum <= CTV_SURR_HI))
                  break_utf8();
               cp_accum = '0;
               cp_class = CLASS_NONE;
            end
         end
      end
      if (!b.last)
         return 1'b0;

      // Rank the checks: times, length, blank text, decode, control bytes.
      if (b.finish_us <= b.start_us)
         verdict = KIND_TIME;
      else if (seg_bytes > {1'b0, text_limit})
         verdict = KIND_LONG;
      else if (!any_visible)
         verdict = KIND_EMPTY;
      else if (utf8_broken || cont_left != 0)
         verdict = KIND_UTF8;
      else if (ctrl_seen)
         verdict = KIND_CONTROL;

      seg_bytes = '0;
      cont_left = '0;
      cp_accum = '0;
      cp_class = CLASS_NONE;
      any_visible = 1'b0;
      utf8_broken = 1'b0;
      ctrl_seen = 1'b0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------------------------------

   // Mostly back to back or short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic longint rand_time();
      return {$urandom, $urandom};
   endfunction

   task automatic push_text(input logic [7:0] text);
      seg_beats.push_back('{text, 1'b1, 1'b0, rand_time(), rand_time()});
   endtask

   // Encode cp with len bytes (forced, so overlong forms come out too); keep the first few.
   task automatic push_utf8(input logic [CTV_CP_W-1:0] cp, input int len, input int keep);
      logic [7:0] seq[4];
      case (len)
         2:       seq = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}, 8'h00, 8'h00};
         3:       seq = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}, 8'h00};
         default: seq = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]},
                          {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
      endcase
      for (int i = 0; i < keep; i++)
         push_text(seq[i]);
   endtask

   function automatic logic [CTV_CP_W-1:0] legal_cp(input int len);
      logic [CTV_CP_W-1:0] cp;
      case (len)
         2: cp = CTV_CP_W'($urandom_range(32'h80, 32'h7FF));
         3: begin
            cp = CTV_CP_W'($urandom_range(32'h800, 32'hFFFF));
            // steer out of the surrogate block
            if (cp >= CTV_SURR_LO && cp <= CTV_SURR_HI)
               cp ^= 21'h2000;
         end
         default: cp = CTV_CP_W'($urandom_range(32'h10000, 32'h10FFFF));
      endcase
      return cp;
   endfunction

   // Assemble one segment: mostly well-formed text, salted with every kind of fault.
   task automatic build_segment();
      int          chunks;
      int          r;
      int          len;
      longint      t_a;
      longint      t_b;
      longint      t_swap;
      logic [31:0] floor_val;
      seg_beats.delete();
      r = $urandom_range(0, 9);
      chunks = (r < 7) ? $urandom_range(0, 4) : (r < 9) ? $urandom_range(5, 10)
                                                        : $urandom_range(11, 20);
      repeat (chunks) begin
         r = $urandom_range(0, 99);
         len = $urandom_range(2, 4);
         if (r < 35) begin
            push_text(8'($urandom_range(8'h21, 8'h7E)));
         end else if (r < 45) begin
            case ($urandom_range(0, 3))
               0: push_text(CTV_CHR_SPACE);
               1: push_text(CTV_CHR_TAB);
               2: push_text(CTV_CHR_LF);
               default: push_text(CTV_CHR_CR);
            endcase
         end else if (r < 50) begin
            push_text(8'($urandom_range(0, 8'h1F)));
         end else if (r < 77) begin
            push_utf8(legal_cp(len), len, len);
         end else if (r < 80) begin
            push_text(8'($urandom));
         end else if (r < 83) begin
            // overlong: a small code point spelled with too many bytes
            floor_val = (len == 2) ? 32'h80 : (len == 3) ? 32'h800 : 32'h10000;
            push_utf8(CTV_CP_W'($urandom_range(0, floor_val - 1)), len, len);
         end else if (r < 86) begin
            push_utf8(CTV_CP_W'($urandom_range(32'hD800, 32'hDFFF)), 3, 3);
         end else if (r < 88) begin
            push_utf8(CTV_CP_W'($urandom_range(32'h110000, 32'h1FFFFF)), 4, 4);
         end else if (r < 91) begin
            // cut the sequence short
            push_utf8(legal_cp(len), len, $urandom_range(1, len - 1));
         end else if (r < 95) begin
            seg_beats.push_back('{8'($urandom), 1'b0, 1'b0, rand_time(), rand_time()});
         end else begin
            push_text(8'($urandom_range(8'h80, 8'hFF)));
         end
      end

      // Close on the final byte, or on a separate beat that carries no byte.
      if (seg_beats.size() == 0 || !seg_beats[seg_beats.size() - 1].valid ||
          $urandom_range(0, 4) == 0)
         seg_beats.push_back('{8'($urandom), 1'b0, 1'b0, 0, 0});

      r = $urandom_range(0, 99);
      t_a = rand_time();
      t_b = rand_time();
      if (r < 80) begin
         if (t_a == t_b)
            t_b = t_a ^ 1;
         if (t_b < t_a) begin
            t_swap = t_a;
            t_a = t_b;
            t_b = t_swap;
         end
      end else if (r < 88) begin
         if (t_b > t_a) begin
            t_swap = t_a;
            t_a = t_b;
            t_b = t_swap;
         end
      end else if (r < 94) begin
         t_b = t_a;
      end else begin
         t_a = T_MIN;
         t_b = (r < 97) ? T_MAX : T_MIN + 1;
      end
      seg_beats[seg_beats.size() - 1].last = 1'b1;
      seg_beats[seg_beats.size() - 1].start_us = t_a;
      seg_beats[seg_beats.size() - 1].finish_us = t_b;
   endtask

   // ---------------------------------------------------------------------------------------
   // Bus drivers
   // ---------------------------------------------------------------------------------------

   // Present one beat after a random gap and hold it until req_tready takes it.
   task automatic send_beat(input text_beat_type b, input bit typed = 1'b0,
                            input ctv_kind_type kind = KIND_NONE);
      int           gap;
      ctv_kind_type predicted;
      gap = req_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b.finish_us, b.start_us, b.text};
      req_tuser <= b.valid;
      req_tlast <= b.last;
      do @(posedge clock); while (!req_tready);
      if (b.valid || b.last)
         text_items++;
      if (absorb_text_beat(b, predicted))
         pending_verdicts.push_back(typed ? kind : predicted);
   endtask

   // Drop valid and hold off until every owed verdict is back, then let the block settle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Optionally write max_text_bytes, then read it back in a back-to-back transfer.
   task automatic set_text_limit(input bit do_write, input logic [15:0] value);
      logic [CTV_DATA_W-1:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= LIMIT_ADDR;
      if (do_write) begin
         csr_pwrite <= 1'b1;
         csr_pwdata <= CTV_DATA_W'(value);
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         text_limit = value;
         csr_penable <= 1'b0;
      end
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== CTV_DATA_W'(text_limit))
         flag_mismatch($sformatf("max_text_bytes reads %0h, expected %0h", readback,
                                 text_limit));
   endtask

   // ---------------------------------------------------------------------------------------
   // Directed table: extremes, each verdict, and the corner cases of the decoder.
   // ---------------------------------------------------------------------------------------
   probe_row_type probe_rows[28] = '{
      // empty text: a closing beat with no byte
      '{'{8'h00, 1'b0, 1'b1, 0, 1}, 1'b1, KIND_EMPTY},
      // equal times
      '{'{8'h41, 1'b1, 1'b1, -1, -1}, 1'b1, KIND_TIME},
      // reversed extreme times beat a bad lead byte
      '{'{8'hFF, 1'b1, 1'b1, T_MAX, T_MIN}, 1'b1, KIND_TIME},
      // widest legal time span
      '{'{8'h7E, 1'b1, 1'b1, T_MIN, T_MAX}, 1'b1, KIND_NONE},
      // whitespace only: tab, carriage return, space
      '{'{8'h09, 1'b1, 1'b0, 0, 0}, 1'b0, KIND_NONE},
      '{'{8'h0D, 1'b1, 1'b0, 0, 0}, 1'b0, KIND_NONE},
      '{'{8'h20, 1'b1, 1'b1, 0, 1}, 1'b1, KIND_EMPTY},
      // ignored beat mid-segment, newline is not a control byte
      '{'{8'h41, 1'b1, 1'b0, 0, 0}, 1'b0, KIND_NONE},
      '{'{8'hFF, 1'b0, 1'b0, 0, 0}, 1'b0, KIND_NONE},
      '{'{8'h0A, 1'b1, 1'b1, 0, 1}, 1'b0, KIND_NONE},
      // NUL is visible but a control byte
      '{'{8'h00, 1'b1, 1'b1, 0, 1}, 1'b1, KIND_CONTROL},
      // overlong two-byte form
      '{'{8'hC0, 1'b1, 1'b0, 0, 0}, 1'b0, KIND_NONE},
      '{'{8'h80, 1'b1, 1'b1, 0, 1}, 1'b1, KIND_UTF8},
      // surrogate half
      '{'{8'hED, 1'b1, 1'b0, 0, 0}, 1'b0, KIND_NONE},
      '{'{8'hA0, 1'b1, 1'b0, 0, 0}, 1'b0, KIND_NONE},
      '{'{8'h80, 1'b1, 1'b1, 0, 1}, 1'b1, KIND_UTF8},
      // just past the last code point
      '{'{8'hF4, 1'b1, 1'b0, 0, 0}, 1'b0, KIND_NONE},
      '{'{8'h90, 1'b1, 1'b0, 0, 0}, 1'b0, KIND_NONE},
      '{'{8'h80, 1'b1, 1'b0, 0, 0}, 1'b0, KIND_NONE},
      '{'{8'h80, 1'b1, 1'b1, 0, 1}, 1'b1, KIND_UTF8},
      // sequence still open at the end
      '{'{8'hE2, 1'b1, 1'b0, 0, 0}, 1'b0, KIND_NONE},
      '{'{8'h82, 1'b1, 1'b1, 0, 1}, 1'b1, KIND_UTF8},
      // the last code point itself
      '{'{8'hF4, 1'b1, 1'b0, 0, 0}, 1'b0, KIND_NONE},
      '{'{8'h8F, 1'b1, 1'b0, 0, 0}, 1'b0, KIND_NONE},
      '{'{8'hBF, 1'b1, 1'b0, 0, 0}, 1'b0, KIND_NONE},
      '{'{8'hBF, 1'b1, 1'b1, 0, 1}, 1'b0, KIND_NONE},
      // lead byte followed by ASCII instead of a continuation
      '{'{8'hC3, 1'b1, 1'b0, 0, 0}, 1'b0, KIND_NONE},
      '{'{8'h41, 1'b1, 1'b1, 0, 1}, 1'b1, KIND_UTF8}
   };

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------
   initial begin
      logic [15:0] limit;
      int          target;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // The limit must come out of reset at its default.
      set_text_limit(1'b0, '0);

      foreach (probe_rows[i])
         send_beat(probe_rows[i].beat, probe_rows[i].typed, probe_rows[i].kind);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            // Reconfigure only with the block idle.
            drain_results();
            case (p)
               1: limit = 16'h0000;
               2: limit = 16'hFFFF;
               3, 4: limit = 16'($urandom_range(1, 12));
               default: limit = CTV_MAX_BYTES_RESET;
            endcase
            set_text_limit(1'b1, limit);
         end

         target = text_items + ITEMS_PER_PHASE;
         while (text_items < target) begin
            build_segment();
            req_calm = ($urandom_range(0, 4) == 0);
            // Now and then let the result side run completely dry first.
            if ($urandom_range(0, 19) == 0)
               drain_results();
            foreach (seg_beats[i])
               send_beat(seg_beats[i]);
         end
         req_calm = 1'b0;
      end

      drain_results();
      repeat (8) @(posedge clock);

      $display("Sent %0d text beats; max_text_bytes went through 4096, 0, 65535 and small limits",
               text_items);
      $display("Verdicts checked: none %0d, time %0d, long %0d, empty %0d, utf8 %0d, control %0d",
               kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3], kind_tally[4],
               kind_tally[5]);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Result side back-pressure: bursts of ready, short stalls, a few long ones,
   // and now and then a long stretch with no stall at all.
   initial begin
      int run;
      int stall;
      @(posedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Check every verdict beat against the oldest owed verdict.
   always @(posedge clock) begin : check_verdicts
      ctv_kind_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            flag_mismatch($sformatf("verdict beat %02h with no segment outstanding",
                                    rsp_tdata));
         end else begin
            want = pending_verdicts.pop_front();
            kind_tally[int'(want)]++;
            if (rsp_tdata !== {5'b00000, want})
               flag_mismatch($sformatf("rsp_tdata %02h, expected error_kind %0d (%s)",
                                       rsp_tdata, want, want.name()));
            if (rsp_tuser !== (want == KIND_NONE))
               flag_mismatch($sformatf("segment_ok %b, expected %b for %s", rsp_tuser,
                                       (want == KIND_NONE), want.name()));
         end
      end
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #4_000_000;
      $display("Timeout with %0d verdicts still owed", pending_verdicts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ sim.f @@
src/ctv_pkg.sv
src/ctv_utf8_dec.sv
src/ctv_seg_track.sv
src/caption_text_validator.sv
sim/tb_caption_text_validator.sv
